// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared clocked assertion forms; empty when building for synthesis
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_IMPL(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: rtl/mfp_pkg.sv
// ---------------------------------------------------------------------------
// mfp_pkg
// shared types, codes and constants of the multi-family generator
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mfp_pkg;

    // family codes
    localparam logic [2:0] FAM_XOSHIRO_SS = 3'd0;
    localparam logic [2:0] FAM_XOSHIRO_PP = 3'd1;
    localparam logic [2:0] FAM_XOROSHIRO  = 3'd2;
    localparam logic [2:0] FAM_PCG32      = 3'd3;
    localparam logic [2:0] FAM_SPLITMIX   = 3'd4;
    localparam logic [2:0] FAM_XORSHIFT   = 3'd5;
    localparam logic [2:0] FAM_XOSHIRO    = 3'd6;
    localparam logic [2:0] FAM_SPARE      = 3'd7;

    // request kind carried on tuser
    localparam logic OP_RESEED = 1'b0;
    localparam logic OP_NEXT   = 1'b1;

    // arithmetic constants
    localparam logic [63:0] SM_GAMMA = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] SM_MUL1  = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] SM_MUL2  = 64'h94D049BB133111EB;
    localparam logic [63:0] PCG_MUL  = 64'd6364136223846793005;
    localparam logic [63:0] PCG_INC  = 64'd1442695040888963407;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SM_ADD,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_X27,
        S_X31,
        S_FIX,
        S_OUT_A,
        S_OUT_B,
        S_STEP,
        S_PCG_ST,
        S_EMIT
    } t_state;

    // datapath micro-operations
    typedef enum logic [3:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_SM_ADD,
        DP_MUL0,
        DP_MUL1,
        DP_MUL2,
        DP_X27,
        DP_X31,
        DP_FIX,
        DP_OUT_A,
        DP_OUT_B,
        DP_STEP,
        DP_PCG_ST,
        DP_EMIT
    } t_dp_op;

    // multiplier constant select
    typedef enum logic [1:0] {
        K_MUL1,
        K_MUL2,
        K_PCG
    } t_ksel;

    // command from controller to datapath
    typedef struct packed {
        t_dp_op     op;
        logic [1:0] idx;
        t_ksel      ksel;
        logic       is_next;
        logic [2:0] family;
    } t_dp_cmd;

    // rotate left by a constant amount
    function automatic logic [63:0] rol64(input logic [63:0] x, input logic [5:0] k);
        return (x << k) | (x >> (7'd64 - {1'b0, k}));
    endfunction

endpackage

// File: rtl/mfp_ctrl.sv
// ---------------------------------------------------------------------------
// mfp_ctrl
// sequencer for reseed and next requests, family register, output valid
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mfp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  logic            i_op,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [2:0]      i_cfg_data,
    output mfp_pkg::t_dp_cmd o_cmd
);
    import mfp_pkg::*;

    t_state     r_state, n_state;
    logic [2:0] r_family, n_family;
    logic       r_is_next, n_is_next;
    logic [1:0] r_idx, n_idx;
    t_ksel      r_ksel, n_ksel;
    logic       r_out_valid, n_out_valid;

    logic       in_acc;
    logic       emit_go;
    logic [2:0] eff_family;

    // code seven behaves as splitmix64
    assign eff_family = (r_family == FAM_SPARE) ? FAM_SPLITMIX : r_family;
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign emit_go    = (r_state == S_EMIT) && (!r_out_valid || i_m_tready);

    // next state
    always_comb begin
        n_state     = r_state;
        n_family    = r_family;
        n_is_next   = r_is_next;
        n_idx       = r_idx;
        n_ksel      = r_ksel;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        if (i_cfg_valid) begin
            n_family = i_cfg_data;
        end
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_idx = 2'd0;
                    if (i_op == OP_NEXT) begin
                        n_is_next = 1'b1;
                        case (eff_family) inside
                            FAM_SPLITMIX:                      n_state = S_SM_ADD;
                            FAM_PCG32, FAM_XORSHIFT, FAM_XOSHIRO: n_state = S_OUT_B;
                            default:                           n_state = S_OUT_A;
                        endcase
                    end else begin
                        n_is_next = 1'b0;
                        n_state   = S_SM_ADD;
                    end
                end
            end
            S_SM_ADD: begin
                n_ksel  = K_MUL1;
                n_state = S_MUL0;
            end
            S_MUL0: n_state = S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: begin
                unique case (r_ksel)
                    K_MUL1:  n_state = S_X27;
                    K_MUL2:  n_state = S_X31;
                    default: n_state = S_PCG_ST;
                endcase
            end
            S_X27: begin
                n_ksel  = K_MUL2;
                n_state = S_MUL0;
            end
            S_X31: begin
                if (r_is_next) begin
                    n_state = S_EMIT;
                end else if (r_idx == 2'd3) begin
                    n_state = S_FIX;
                end else begin
                    n_idx   = r_idx + 2'd1;
                    n_state = S_SM_ADD;
                end
            end
            S_FIX:   n_state = S_IDLE;
            S_OUT_A: n_state = S_OUT_B;
            S_OUT_B: begin
                if (eff_family == FAM_PCG32) begin
                    n_ksel  = K_PCG;
                    n_state = S_MUL0;
                end else begin
                    n_state = S_STEP;
                end
            end
            S_STEP:   n_state = S_EMIT;
            S_PCG_ST: n_state = S_EMIT;
            S_EMIT: begin
                if (emit_go) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and datapath command
    always_comb begin
        o_s_tready     = (r_state == S_IDLE);
        o_m_tvalid     = r_out_valid;
        o_cfg_ready    = 1'b1;
        o_cmd.idx      = r_idx;
        o_cmd.ksel     = r_ksel;
        o_cmd.is_next  = r_is_next;
        o_cmd.family   = eff_family;
        unique case (r_state)
            S_IDLE:   o_cmd.op = (in_acc && i_op == OP_RESEED) ? DP_CAPTURE : DP_NOP;
            S_SM_ADD: o_cmd.op = DP_SM_ADD;
            S_MUL0:   o_cmd.op = DP_MUL0;
            S_MUL1:   o_cmd.op = DP_MUL1;
            S_MUL2:   o_cmd.op = DP_MUL2;
            S_X27:    o_cmd.op = DP_X27;
            S_X31:    o_cmd.op = DP_X31;
            S_FIX:    o_cmd.op = DP_FIX;
            S_OUT_A:  o_cmd.op = DP_OUT_A;
            S_OUT_B:  o_cmd.op = DP_OUT_B;
            S_STEP:   o_cmd.op = DP_STEP;
            S_PCG_ST: o_cmd.op = DP_PCG_ST;
            S_EMIT:   o_cmd.op = emit_go ? DP_EMIT : DP_NOP;
            default:  o_cmd.op = DP_NOP;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_family    <= FAM_XOSHIRO_SS;
            r_is_next   <= 1'b0;
            r_idx       <= 2'd0;
            r_ksel      <= K_MUL1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_family    <= n_family;
            r_is_next   <= n_is_next;
            r_idx       <= n_idx;
            r_ksel      <= n_ksel;
            r_out_valid <= n_out_valid;
        end
    end

    // checks
    `ASSERT_IMPL(a_emit_only_next, r_state == S_EMIT, r_is_next, "emit during reseed")
    `ASSERT_NEXT(a_accept_leaves_idle, in_acc, r_state != S_IDLE, "accept did not start work")
    `ASSERT_IMPL(a_valid_from_emit, $rose(r_out_valid), $past(r_state == S_EMIT),
                 "output valid without emit")
    `ASSERT_IMPL(a_idx_seed_only, r_idx != 2'd0, !r_is_next, "word index moved on next request")

endmodule

// File: rtl/mfp_dpath.sv
// ---------------------------------------------------------------------------
// mfp_dpath
// state words, splitmix mixer, shared 32x32 multiplier and family steps
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfp_dpath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mfp_pkg::t_dp_cmd i_cmd,
    input  logic [63:0]      i_seed,
    output logic [63:0]      o_value
);
    import mfp_pkg::*;

    logic [63:0] r_w [4];
    logic [63:0] r_z;
    logic [63:0] r_t;
    logic [63:0] r_acc;
    logic [63:0] r_seed;
    logic [63:0] r_res;
    logic [63:0] r_out;

    logic [63:0] kconst;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [63:0] sm_base, sm_sum;
    logic [63:0] x27_val, x31_val;
    logic [63:0] ss_src, ss_mul5;
    logic [63:0] pcg_xs64;
    logic [31:0] pcg_xs;
    logic [63:0] pcg_rot2;
    logic [31:0] pcg_out;
    logic [63:0] xs_t, xs_w2, xs_w3;
    logic [63:0] xo_b;
    logic [63:0] xr_x;

    // multiplier constant and partial-product operands
    always_comb begin
        case (i_cmd.ksel)
            K_MUL1:  kconst = SM_MUL1;
            K_MUL2:  kconst = SM_MUL2;
            default: kconst = PCG_MUL;
        endcase
        case (i_cmd.op)
            DP_MUL1: begin
                mul_a = r_t[31:0];
                mul_b = kconst[63:32];
            end
            DP_MUL2: begin
                mul_a = r_t[63:32];
                mul_b = kconst[31:0];
            end
            default: begin
                mul_a = r_t[31:0];
                mul_b = kconst[31:0];
            end
        endcase
    end

    assign prod = {32'd0, mul_a} * {32'd0, mul_b};

    // splitmix add and xor-shifts
    assign sm_base = i_cmd.is_next ? r_w[0] : r_z;
    assign sm_sum  = sm_base + SM_GAMMA;
    assign x27_val = r_acc ^ (r_acc >> 27);
    assign x31_val = r_acc ^ (r_acc >> 31);

    // star-star first half: rotate of times five
    assign ss_src  = (i_cmd.family == FAM_XOROSHIRO) ? r_w[0] : r_w[1];
    assign ss_mul5 = (ss_src << 2) + ss_src;

    // pcg32 xsh-rr output from the old word
    assign pcg_xs64 = ((r_w[0] >> 18) ^ r_w[0]) >> 27;
    assign pcg_xs   = pcg_xs64[31:0];
    assign pcg_rot2 = {pcg_xs, pcg_xs} >> r_w[0][63:59];
    assign pcg_out  = pcg_rot2[31:0];

    // xoshiro256 step terms
    assign xs_t  = r_w[1] << 17;
    assign xs_w2 = r_w[2] ^ r_w[0];
    assign xs_w3 = r_w[3] ^ r_w[1];

    // xoroshiro128 and xorshift128+ terms
    assign xo_b = r_w[1] ^ r_w[0];
    assign xr_x = r_w[0] ^ (r_w[0] << 23);

    // state words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_w[i] <= 64'd0;
            end
        end else begin
            case (i_cmd.op)
                DP_SM_ADD: begin
                    if (i_cmd.is_next) begin
                        r_w[0] <= sm_sum;
                    end
                end
                DP_X31: begin
                    if (!i_cmd.is_next) begin
                        r_w[i_cmd.idx] <= x31_val;
                    end
                end
                DP_FIX: begin
                    if (i_cmd.family == FAM_PCG32 || i_cmd.family == FAM_SPLITMIX) begin
                        r_w[0] <= r_seed;
                    end else if ((r_w[0] | r_w[1] | r_w[2] | r_w[3]) == 64'd0) begin
                        r_w[0] <= 64'd1;
                    end
                end
                DP_STEP: begin
                    case (i_cmd.family)
                        FAM_XOROSHIRO: begin
                            r_w[0] <= rol64(r_w[0], 6'd24) ^ xo_b ^ (xo_b << 16);
                            r_w[1] <= rol64(xo_b, 6'd37);
                        end
                        FAM_XORSHIFT: begin
                            r_w[0] <= r_w[1];
                            r_w[1] <= xr_x ^ r_w[1] ^ (xr_x >> 18) ^ (r_w[1] >> 5);
                        end
                        default: begin
                            r_w[0] <= r_w[0] ^ xs_w3;
                            r_w[1] <= r_w[1] ^ xs_w2;
                            r_w[2] <= xs_w2 ^ xs_t;
                            r_w[3] <= rol64(xs_w3, 6'd45);
                        end
                    endcase
                end
                DP_PCG_ST: r_w[0] <= r_acc + PCG_INC;
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_CAPTURE: begin
                r_z    <= i_seed;
                r_seed <= i_seed;
            end
            DP_SM_ADD: begin
                r_z <= sm_sum;
                r_t <= sm_sum ^ (sm_sum >> 30);
            end
            DP_MUL0: r_acc <= prod;
            DP_MUL1: r_acc <= r_acc + {prod[31:0], 32'd0};
            DP_MUL2: r_acc <= r_acc + {prod[31:0], 32'd0};
            DP_X27:  r_t   <= x27_val;
            DP_X31: begin
                if (i_cmd.is_next) begin
                    r_res <= x31_val;
                end
            end
            DP_OUT_A: begin
                if (i_cmd.family == FAM_XOSHIRO_PP) begin
                    r_t <= rol64(r_w[0] + r_w[3], 6'd23);
                end else begin
                    r_t <= rol64(ss_mul5, 6'd7);
                end
            end
            DP_OUT_B: begin
                case (i_cmd.family)
                    FAM_XOSHIRO_PP: r_res <= r_t + r_w[0];
                    FAM_XOSHIRO:    r_res <= r_w[0];
                    FAM_XORSHIFT:   r_res <= r_w[0] + r_w[1];
                    FAM_PCG32: begin
                        r_res <= {32'd0, pcg_out};
                        r_t   <= r_w[0];
                    end
                    default:        r_res <= r_t + (r_t << 3);
                endcase
            end
            DP_EMIT: r_out <= r_res;
            default: ;
        endcase
    end

    assign o_value = r_out;

endmodule

// File: rtl/multi_family_prng_core.sv
// ---------------------------------------------------------------------------
// multi_family_prng_core
// seven-family 64-bit pseudo-random generator with splitmix64 reseed
// ---------------------------------------------------------------------------
// channel   dir  handshake                payload
// s_axis    in   i_s_tvalid / o_s_tready  tuser: op, tdata: seed
// m_axis    out  o_m_tvalid / i_m_tready  tdata: value
// cfg       in   i_cfg_valid / o_cfg_ready  family code
//
// next request: raw xoshiro and xorshift128+ run OUT_B, STEP; star-star, plus-plus
// add OUT_A first; pcg32 multiplies after OUT_B; splitmix64 mixes once. reseed:
// four splitmix64 mixes; shared 32x32 multiplier steps MUL0, MUL1, MUL2.
// one request in flight; a finished value waits in the output register while
// the next request is taken; emission holds while it is full and i_m_tready is low.
// reset clears state words, family and the output valid flag.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_family_prng_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [0:0]  i_s_tuser,   // [0] op
    input  logic [63:0] i_s_tdata,   // [63:0] seed
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [63:0] value
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_data
);
    import mfp_pkg::*;

    t_dp_cmd cmd;

    // sequencer
    mfp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_op        (i_s_tuser[0]),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_cmd       (cmd)
    );

    // arithmetic and state
    mfp_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_seed  (i_s_tdata),
        .o_value (o_m_tdata)
    );

endmodule
